// ----- design/gil_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// gil_pkg
// Shared constants and controller/datapath interface types for the
// generalized Hilbert curve index to coordinate converter.
// ----------------------------------------------------------------------------
package gil_pkg;

	localparam int MAX_DIM_DEF = 256;
	localparam int IDX_W       = 16;
	localparam int COORD_W     = 8;
	localparam int CFG_W       = 9;
	localparam int CFG_IDX_W   = 1;

	localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 1'b1;

	typedef struct packed {
		logic load;
		logic step;
	} gil_cmd_t;

	typedef struct packed {
		logic out_of_range;
		logic finished;
	} gil_status_t;

endpackage

`default_nettype wire

// ----- design/gilbert_index_to_xy.sv -----
// Operation: an accepted item is subdivided one level per cycle down to a
// unit-wide run, which is then walked in its final straight step; done is
// high the cycle after that step. An index out of range raises done in the
// cycle after acceptance. Start is ignored while busy; a new start is taken
// in the done cycle.
// Reset: arst_n clears the sequencer and sets both dimensions to 16.
`default_nettype none
// ----------------------------------------------------------------------------
// gilbert_index_to_xy
// Converts a position along a generalized Hilbert curve covering a
// configurable rectangle into column and row coordinates.
// ----------------------------------------------------------------------------
module gilbert_index_to_xy
	import gil_pkg::*;
#(
	parameter int MAX_DIM = MAX_DIM_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_data,
	input  wire logic                 start,
	input  wire logic [IDX_W-1:0]     curve_index,
	output logic                      busy,
	output logic                      done,
	output logic [COORD_W-1:0]        coord_x,
	output logic [COORD_W-1:0]        coord_y,
	output logic                      out_of_range
);

	localparam int CW = $clog2(MAX_DIM + 1);

	logic [CFG_W-1:0] grid_width_q, grid_height_q;
	logic [CW-1:0]    dim_w, dim_h;
	gil_cmd_t         cmd;
	gil_status_t      status;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_width_q  <= CFG_W'(16);
			grid_height_q <= CFG_W'(16);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_GRID_WIDTH:  grid_width_q  <= cfg_data;
				REG_GRID_HEIGHT: grid_height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Dimensions above the supported maximum saturate.
	assign dim_w = (32'(grid_width_q) > 32'(MAX_DIM)) ? CW'(MAX_DIM) : CW'(grid_width_q);
	assign dim_h = (32'(grid_height_q) > 32'(MAX_DIM)) ? CW'(MAX_DIM) : CW'(grid_height_q);

	gil_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.status (status),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	gil_datapath #(
		.MAX_DIM (MAX_DIM)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.curve_index  (curve_index),
		.dim_w        (dim_w),
		.dim_h        (dim_h),
		.status       (status),
		.coord_x      (coord_x),
		.coord_y      (coord_y),
		.out_of_range (out_of_range)
	);

endmodule

`default_nettype wire

// ----- design/gil_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// gil_ctrl
// Sequencer: accepts an item, steps the datapath one subdivision level per
// cycle down to a unit-wide run and walks it, then presents the result.
// ----------------------------------------------------------------------------
module gil_ctrl
	import gil_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire gil_status_t status,
	output gil_cmd_t         cmd,
	output logic             busy,
	output logic             done
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_RUN  = 2'd1;
	localparam logic [1:0] S_DONE = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       accept;

	assign busy     = (state_q == S_RUN);
	assign done     = (state_q == S_DONE);
	assign accept   = start && !busy;
	assign cmd.load = accept;
	assign cmd.step = busy;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE, S_DONE: begin
				if (accept) begin
					state_d = status.out_of_range ? S_DONE : S_RUN;
				end else begin
					state_d = S_IDLE;
				end
			end
			S_RUN: begin
				if (status.finished) begin
					state_d = S_DONE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

`default_nettype wire

// ----- design/gil_datapath.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// gil_datapath
// Holds the current major and minor vectors, the running corner position and
// the base index, and per step performs one subdivision or the final walk.
// ----------------------------------------------------------------------------
module gil_datapath
	import gil_pkg::*;
#(
	parameter int MAX_DIM = MAX_DIM_DEF
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire gil_cmd_t                           cmd,
	input  wire logic [IDX_W-1:0]                   curve_index,
	input  wire logic [$clog2(MAX_DIM+1)-1:0]       dim_w,
	input  wire logic [$clog2(MAX_DIM+1)-1:0]       dim_h,
	output gil_status_t                             status,
	output logic [COORD_W-1:0]                      coord_x,
	output logic [COORD_W-1:0]                      coord_y,
	output logic                                    out_of_range
);

	localparam int CW  = $clog2(MAX_DIM + 1);
	localparam int DW  = CW + 1;
	localparam int PXW = CW + 2;
	localparam int PW  = ((2 * CW > IDX_W) ? 2 * CW : IDX_W) + 1;

	localparam logic signed [DW-1:0] V_ONE  = DW'(1);
	localparam logic signed [DW-1:0] V_MONE = -V_ONE;
	localparam logic signed [DW-1:0] V_ZERO = '0;

	function automatic logic signed [DW-1:0] sgn(input logic signed [DW-1:0] v);
		logic signed [DW-1:0] r;
		if (v[DW-1]) r = V_MONE;
		else if (v != V_ZERO) r = V_ONE;
		else r = V_ZERO;
		return r;
	endfunction

	// Halving that truncates toward zero.
	function automatic logic signed [DW-1:0] half(input logic signed [DW-1:0] v);
		logic signed [DW-1:0] t;
		t = v + $signed({{(DW-1){1'b0}}, v[DW-1]});
		return t >>> 1;
	endfunction

	function automatic logic [CW-1:0] mag(input logic signed [DW-1:0] v);
		logic signed [DW-1:0] t;
		t = v[DW-1] ? -v : v;
		return CW'(t);
	endfunction

	function automatic logic signed [PXW-1:0] ext(input logic signed [DW-1:0] v);
		return PXW'(v);
	endfunction

	logic signed [DW-1:0]  ax_q, ay_q, bx_q, by_q;
	logic signed [DW-1:0]  ax_d, ay_d, bx_d, by_d;
	logic signed [PXW-1:0] px_q, py_q, px_d, py_d;
	logic [IDX_W-1:0]      target_q, base_q, base_d;
	logic                  oor_q;

	logic [CW-1:0]         w, h, w2, h2, w2c, h2c, hr, m1a, m1b;
	logic signed [DW-1:0]  dax, day, dbx, dby;
	logic signed [DW-1:0]  ax2, ay2, bx2, by2, ax2c, ay2c, bx2c, by2c;
	logic                  corr_a, corr_b, split_a, lt1, lt2, terminal;
	logic [PW-1:0]         p1, p2, di_ext, total;
	logic [IDX_W-1:0]      di;
	logic signed [PXW-1:0] dis;

	assign w   = mag(ax_q + ay_q);
	assign h   = mag(bx_q + by_q);
	assign dax = sgn(ax_q);
	assign day = sgn(ay_q);
	assign dbx = sgn(bx_q);
	assign dby = sgn(by_q);
	assign ax2 = half(ax_q);
	assign ay2 = half(ay_q);
	assign bx2 = half(bx_q);
	assign by2 = half(by_q);
	assign w2  = mag(ax2 + ay2);
	assign h2  = mag(bx2 + by2);

	assign split_a = ((PXW'(w) << 1) > (PXW'(h) * PXW'(3)));
	assign corr_a  = w2[0] && (w > CW'(2));
	assign corr_b  = h2[0] && (h > CW'(2));
	assign ax2c    = corr_a ? ax2 + dax : ax2;
	assign ay2c    = corr_a ? ay2 + day : ay2;
	assign w2c     = w2 + CW'(corr_a);
	assign bx2c    = corr_b ? bx2 + dbx : bx2;
	assign by2c    = corr_b ? by2 + dby : by2;
	assign h2c     = h2 + CW'(corr_b);
	assign hr      = h - h2c;

	// One shared multiplier for the first sub-rectangle's size, one for the second.
	assign m1a = split_a ? w2c : h2c;
	assign m1b = split_a ? h : w2;
	assign p1  = PW'(m1a) * PW'(m1b);
	assign p2  = PW'(w) * PW'(hr);

	assign di       = target_q - base_q;
	assign di_ext   = PW'(di);
	assign lt1      = di_ext < p1;
	assign lt2      = di_ext < (p1 + p2);
	assign dis      = $signed({2'b00, di[CW-1:0]});
	assign terminal = (h == CW'(1)) || (w == CW'(1));

	assign total               = PW'(dim_w) * PW'(dim_h);
	assign status.out_of_range = (PW'(curve_index) >= total);
	assign status.finished     = terminal;

	always_comb begin
		ax_d   = ax_q;
		ay_d   = ay_q;
		bx_d   = bx_q;
		by_d   = by_q;
		px_d   = px_q;
		py_d   = py_q;
		base_d = base_q;
		if (h == CW'(1)) begin
			// A single row left: walk straight along the major vector.
			px_d = px_q + (dax[DW-1] ? -dis : ((dax != V_ZERO) ? dis : '0));
			py_d = py_q + (day[DW-1] ? -dis : ((day != V_ZERO) ? dis : '0));
		end else if (w == CW'(1)) begin
			px_d = px_q + (dbx[DW-1] ? -dis : ((dbx != V_ZERO) ? dis : '0));
			py_d = py_q + (dby[DW-1] ? -dis : ((dby != V_ZERO) ? dis : '0));
		end else if (split_a) begin
			if (lt1) begin
				ax_d = ax2c;
				ay_d = ay2c;
			end else begin
				base_d = base_q + IDX_W'(p1);
				px_d   = px_q + ext(ax2c);
				py_d   = py_q + ext(ay2c);
				ax_d   = ax_q - ax2c;
				ay_d   = ay_q - ay2c;
			end
		end else if (lt1) begin
			ax_d = bx2c;
			ay_d = by2c;
			bx_d = ax2;
			by_d = ay2;
		end else if (lt2) begin
			base_d = base_q + IDX_W'(p1);
			px_d   = px_q + ext(bx2c);
			py_d   = py_q + ext(by2c);
			bx_d   = bx_q - bx2c;
			by_d   = by_q - by2c;
		end else begin
			// Third sub-rectangle runs back along the far side, reversed.
			base_d = base_q + IDX_W'(p1 + p2);
			ax_d   = -bx2c;
			ay_d   = -by2c;
			bx_d   = -(ax_q - ax2);
			by_d   = -(ay_q - ay2);
			px_d   = px_q + ext(ax_q) - ext(dax) + ext(bx2c) - ext(dbx);
			py_d   = py_q + ext(ay_q) - ext(day) + ext(by2c) - ext(dby);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oor_q <= 1'b0;
		end else if (cmd.load) begin
			oor_q <= status.out_of_range;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			target_q <= curve_index;
			base_q   <= '0;
			px_q     <= '0;
			py_q     <= '0;
			if (dim_w >= dim_h) begin
				ax_q <= $signed({1'b0, dim_w});
				ay_q <= V_ZERO;
				bx_q <= V_ZERO;
				by_q <= $signed({1'b0, dim_h});
			end else begin
				ax_q <= V_ZERO;
				ay_q <= $signed({1'b0, dim_w});
				bx_q <= $signed({1'b0, dim_h});
				by_q <= V_ZERO;
			end
		end else if (cmd.step) begin
			ax_q   <= ax_d;
			ay_q   <= ay_d;
			bx_q   <= bx_d;
			by_q   <= by_d;
			px_q   <= px_d;
			py_q   <= py_d;
			base_q <= base_d;
		end
	end

	assign coord_x      = COORD_W'(px_q);
	assign coord_y      = COORD_W'(py_q);
	assign out_of_range = oor_q;

endmodule

`default_nettype wire
